/* rtl/gpioei_pkg.sv */
// Shared types, codes and constants of the GPIO port with edge interrupts.
package gpioei_pkg;

	// Default and largest supported number of pins.
	localparam int unsigned PinCountDefault = 8;
	localparam int unsigned MaxPins = 16;

	// Fixed widths of the external ports.
	localparam int unsigned DataW = 32;
	localparam int unsigned PortW = 8;
	localparam int unsigned NibbleW = 4;

	// Bits of one pin's configuration nibble.
	localparam int unsigned ModeLsb = 0;
	localparam int unsigned ModeMsb = 1;
	localparam int unsigned OpenDrainBit = 2;

	// Commands carried by an input word.
	typedef enum logic [1:0] {
		CMD_READ   = 2'b00,
		CMD_WRITE  = 2'b01,
		CMD_SAMPLE = 2'b10,
		CMD_NONE   = 2'b11
	} cmd_t;

	// Register map.
	typedef enum logic [3:0] {
		REG_CONFIG  = 4'd0,
		REG_INPUT   = 4'd1,
		REG_OUTPUT  = 4'd2,
		REG_SET     = 4'd3,
		REG_CLEAR   = 4'd4,
		REG_IRQ_EN  = 4'd5,
		REG_RISE_EN = 4'd6,
		REG_FALL_EN = 4'd7,
		REG_PENDING = 4'd8
	} reg_idx_t;

	// One input word.
	typedef struct packed {
		logic [1:0]       command;
		logic [3:0]       reg_index;
		logic [DataW-1:0] write_data;
		logic [PortW-1:0] pins_in;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [DataW-1:0] read_data;
		logic [PortW-1:0] pins_drive;
		logic [PortW-1:0] pins_enable;
		logic             irq;
	} result_t;

endpackage

/* rtl/gpio_port_with_edge_interrupts.sv */
// Top level of the GPIO port with edge interrupts: input stage and result register.
//
// Each input word is a register read, a register write or a sample of the
// pin levels, handed over on in_valid / in_stall. Each word yields exactly
// one result word on out_valid / out_stall: read data (zero unless a read),
// the output levels, the per-pin drive enables and the interrupt request,
// all as they stand after that word.
// A word is registered in the input stage on acceptance; once the result
// register is free or emptying, it passes through the register update logic
// into the result register, from which its result is offered.
// One word per cycle is sustained while out_stall is low; the single register
// update per cycle sets that figure.
// Reset (arst_n low) clears every port register and empties both stages.
// While the result is stalled it holds; a second word still enters the input
// stage, and in_stall rises only once both stages are full.
module gpio_port_with_edge_interrupts #(
	parameter int unsigned PIN_COUNT = gpioei_pkg::PinCountDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [3:0]                    reg_index,
	input  logic [gpioei_pkg::DataW-1:0]  write_data,
	input  logic [gpioei_pkg::PortW-1:0]  pins_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gpioei_pkg::DataW-1:0]  read_data,
	output logic [gpioei_pkg::PortW-1:0]  pins_drive,
	output logic [gpioei_pkg::PortW-1:0]  pins_enable,
	output logic                          irq
);

	logic                valid_s1;
	gpioei_pkg::item_t   item_s1;
	logic                valid_s2;
	gpioei_pkg::result_t res_s2;
	gpioei_pkg::result_t res_d;
	logic                advance;
	logic                fire;
	logic                accept;

	// The input stage moves on whenever the result register is free or emptying.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command    <= command;
			item_s1.reg_index  <= reg_index;
			item_s1.write_data <= write_data;
			item_s1.pins_in    <= pins_in;
		end
	end

	gpioei_core #(
		.PIN_COUNT(PIN_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (res_d)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid   = valid_s2;
	assign read_data   = res_s2.read_data;
	assign pins_drive  = res_s2.pins_drive;
	assign pins_enable = res_s2.pins_enable;
	assign irq         = res_s2.irq;

endmodule

/* rtl/gpioei_core.sv */
// Register file, edge detection and result logic of the GPIO port.
module gpioei_core #(
	parameter int unsigned PIN_COUNT = gpioei_pkg::PinCountDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  gpioei_pkg::item_t   item,
	output gpioei_pkg::result_t result
);

	localparam int unsigned CfgW =
		(gpioei_pkg::NibbleW * PIN_COUNT > gpioei_pkg::DataW) ?
		gpioei_pkg::DataW : gpioei_pkg::NibbleW * PIN_COUNT;
	localparam int unsigned DrvN =
		(PIN_COUNT < gpioei_pkg::PortW) ? PIN_COUNT : gpioei_pkg::PortW;

	logic [CfgW-1:0]      cfg_q, cfg_d;
	logic [PIN_COUNT-1:0] lvl_q, lvl_d;
	logic [PIN_COUNT-1:0] smp_q, smp_d;
	logic [PIN_COUNT-1:0] ien_q, ien_d;
	logic [PIN_COUNT-1:0] ren_q, ren_d;
	logic [PIN_COUNT-1:0] fen_q, fen_d;
	logic [PIN_COUNT-1:0] pnd_q, pnd_d;

	logic [gpioei_pkg::MaxPins-1:0] pins_wide;
	logic [PIN_COUNT-1:0]           now;
	logic [PIN_COUNT-1:0]           wdata;
	logic [gpioei_pkg::DataW-1:0]   rdata;
	logic [gpioei_pkg::PortW-1:0]   drv_en;

	// Write data and sampled levels trimmed to the pins that exist.
	assign pins_wide = gpioei_pkg::MaxPins'(item.pins_in);
	assign now       = pins_wide[PIN_COUNT-1:0];
	assign wdata     = item.write_data[PIN_COUNT-1:0];

	// Next state and read data for the word in hand.
	always_comb begin
		cfg_d = cfg_q;
		lvl_d = lvl_q;
		smp_d = smp_q;
		ien_d = ien_q;
		ren_d = ren_q;
		fen_d = fen_q;
		pnd_d = pnd_q;
		rdata = '0;
		unique case (gpioei_pkg::cmd_t'(item.command))
			gpioei_pkg::CMD_READ: begin
				unique case (gpioei_pkg::reg_idx_t'(item.reg_index))
					gpioei_pkg::REG_CONFIG:  rdata = gpioei_pkg::DataW'(cfg_q);
					gpioei_pkg::REG_INPUT:   rdata = gpioei_pkg::DataW'(smp_q);
					gpioei_pkg::REG_OUTPUT:  rdata = gpioei_pkg::DataW'(lvl_q);
					gpioei_pkg::REG_IRQ_EN:  rdata = gpioei_pkg::DataW'(ien_q);
					gpioei_pkg::REG_RISE_EN: rdata = gpioei_pkg::DataW'(ren_q);
					gpioei_pkg::REG_FALL_EN: rdata = gpioei_pkg::DataW'(fen_q);
					gpioei_pkg::REG_PENDING: rdata = gpioei_pkg::DataW'(pnd_q);
					default:                 rdata = '0;
				endcase
			end
			gpioei_pkg::CMD_WRITE: begin
				unique case (gpioei_pkg::reg_idx_t'(item.reg_index))
					gpioei_pkg::REG_CONFIG:  cfg_d = item.write_data[CfgW-1:0];
					gpioei_pkg::REG_OUTPUT:  lvl_d = wdata;
					gpioei_pkg::REG_SET:     lvl_d = lvl_q | wdata;
					gpioei_pkg::REG_CLEAR:   lvl_d = lvl_q & ~wdata;
					gpioei_pkg::REG_IRQ_EN:  ien_d = wdata;
					gpioei_pkg::REG_RISE_EN: ren_d = wdata;
					gpioei_pkg::REG_FALL_EN: fen_d = wdata;
					gpioei_pkg::REG_PENDING: pnd_d = pnd_q & ~wdata;
					default: ;
				endcase
			end
			gpioei_pkg::CMD_SAMPLE: begin
				// A selected edge since the last sample sets the pending flag.
				pnd_d = pnd_q | (now & ~smp_q & ren_q) | (~now & smp_q & fen_q);
				smp_d = now;
			end
			default: ;
		endcase
	end

	// A pin drives when its mode is nonzero; open drain drives only a low level.
	always_comb begin
		drv_en = '0;
		for (int p = 0; p < DrvN; p++) begin
			drv_en[p] = (cfg_d[gpioei_pkg::NibbleW*p + gpioei_pkg::ModeLsb +: 2] != 2'b00) &&
				(!cfg_d[gpioei_pkg::NibbleW*p + gpioei_pkg::OpenDrainBit] || !lvl_d[p]);
		end
	end

	// Result reflects the state after this word.
	assign result.read_data   = rdata;
	assign result.pins_drive  = gpioei_pkg::PortW'(lvl_d);
	assign result.pins_enable = drv_en;
	assign result.irq         = |(pnd_d & ien_d);

	// Port state registers, updated as each word leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			lvl_q <= '0;
			smp_q <= '0;
			ien_q <= '0;
			ren_q <= '0;
			fen_q <= '0;
			pnd_q <= '0;
		end else if (fire) begin
			cfg_q <= cfg_d;
			lvl_q <= lvl_d;
			smp_q <= smp_d;
			ien_q <= ien_d;
			ren_q <= ren_d;
			fen_q <= fen_d;
			pnd_q <= pnd_d;
		end
	end

endmodule

/* rtl/gpioei_checker.sv */
// Port-level checks of the GPIO port and the bind that attaches them.
module gpioei_checker #(
	parameter int unsigned PIN_COUNT = gpioei_pkg::PinCountDefault
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [gpioei_pkg::DataW-1:0] read_data,
	input logic [gpioei_pkg::PortW-1:0] pins_drive
);

	// The input side only stalls while a result is held up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// A held result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(pins_drive)))
		else $error("stalled result changed");

	// A result from an empty pipe needs a matching word accepted into the input stage first.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input word");

	// Output levels never show pins beyond the pin count.
	a_pin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((gpioei_pkg::MaxPins'(pins_drive) >> PIN_COUNT) == '0))
		else $error("drive level on a pin that does not exist");

endmodule

bind gpio_port_with_edge_interrupts gpioei_checker #(
	.PIN_COUNT(PIN_COUNT)
) u_gpioei_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_data  (read_data),
	.pins_drive (pins_drive)
);

/* verif/tb_top.sv */
// Self-checking testbench for the GPIO port with edge interrupts: bus words in, result words out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Idling schemes, one per part of the run.
	typedef enum int unsigned {
		PH_SLOW_SINK,
		PH_SLOW_SOURCE,
		PH_FULL_RATE
	} idle_phase_t;

	// One queued word together with the idling scheme it is sent under.
	typedef struct {
		gpioei_pkg::item_t word;
		idle_phase_t       phase;
	} queued_word_t;

	localparam logic [3:0] RegUnmappedLo = 4'd9;
	localparam logic [3:0] RegUnmappedHi = 4'd15;
	localparam int unsigned RandomWords = 1150;
	localparam int unsigned HoldAfterWords = 1000;
	localparam int unsigned HoldCycles = 60;
	localparam int unsigned DrainCycles = 10;
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned ReportedFaults = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [3:0] reg_index = '0;
	logic [gpioei_pkg::DataW-1:0] write_data = '0;
	logic [gpioei_pkg::PortW-1:0] pins_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [gpioei_pkg::DataW-1:0] read_data;
	logic [gpioei_pkg::PortW-1:0] pins_drive;
	logic [gpioei_pkg::PortW-1:0] pins_enable;
	logic irq;

	// Words waiting to be sent and results still due from the port.
	queued_word_t words_to_send[$];
	gpioei_pkg::result_t port_results_due[$];

	// Shadow copy of the port registers.
	logic [gpioei_pkg::DataW-1:0] cfg_shadow = '0;
	logic [gpioei_pkg::PortW-1:0] out_levels = '0;
	logic [gpioei_pkg::PortW-1:0] last_pins = '0;
	logic [gpioei_pkg::PortW-1:0] irq_en = '0;
	logic [gpioei_pkg::PortW-1:0] rise_en = '0;
	logic [gpioei_pkg::PortW-1:0] fall_en = '0;
	logic [gpioei_pkg::PortW-1:0] pending = '0;

	idle_phase_t idle_phase = PH_SLOW_SINK;
	int unsigned words_accepted = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;

	gpio_port_with_edge_interrupts dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.reg_index(reg_index),
		.write_data(write_data),
		.pins_in(pins_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.pins_drive(pins_drive),
		.pins_enable(pins_enable),
		.irq(irq)
	);

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one accepted word to the shadow registers and record the result it must give.
	task automatic apply_bus_word(input gpioei_pkg::item_t w);
		gpioei_pkg::result_t r;
		logic [gpioei_pkg::PortW-1:0] rise;
		logic [gpioei_pkg::PortW-1:0] fall;
		logic [gpioei_pkg::NibbleW-1:0] nib;
		int p;
		r = '0;
		case (w.command)
			gpioei_pkg::CMD_READ: begin
				case (w.reg_index)
					gpioei_pkg::REG_CONFIG:  r.read_data = cfg_shadow;
					gpioei_pkg::REG_INPUT:   r.read_data = {24'b0, last_pins};
					gpioei_pkg::REG_OUTPUT:  r.read_data = {24'b0, out_levels};
					gpioei_pkg::REG_IRQ_EN:  r.read_data = {24'b0, irq_en};
					gpioei_pkg::REG_RISE_EN: r.read_data = {24'b0, rise_en};
					gpioei_pkg::REG_FALL_EN: r.read_data = {24'b0, fall_en};
					gpioei_pkg::REG_PENDING: r.read_data = {24'b0, pending};
					default:                 r.read_data = '0;
				endcase
			end
			gpioei_pkg::CMD_WRITE: begin
				case (w.reg_index)
					gpioei_pkg::REG_CONFIG:  cfg_shadow = w.write_data;
					gpioei_pkg::REG_OUTPUT:  out_levels = w.write_data[7:0];
					gpioei_pkg::REG_SET:     out_levels = out_levels | w.write_data[7:0];
					gpioei_pkg::REG_CLEAR:   out_levels = out_levels & ~w.write_data[7:0];
					gpioei_pkg::REG_IRQ_EN:  irq_en = w.write_data[7:0];
					gpioei_pkg::REG_RISE_EN: rise_en = w.write_data[7:0];
					gpioei_pkg::REG_FALL_EN: fall_en = w.write_data[7:0];
					gpioei_pkg::REG_PENDING: pending = pending & ~w.write_data[7:0];
					default: ;
				endcase
			end
			gpioei_pkg::CMD_SAMPLE: begin
				// Enabled edges since the previous sample raise their pending flags.
				rise = w.pins_in & ~last_pins & rise_en;
				fall = ~w.pins_in & last_pins & fall_en;
				pending = pending | rise | fall;
				last_pins = w.pins_in;
			end
			default: ;
		endcase
		// A pin drives in any non-input mode; open drain drives only a low level.
		for (p = 0; p < gpioei_pkg::PortW; p++) begin
			nib = cfg_shadow[gpioei_pkg::NibbleW*p +: gpioei_pkg::NibbleW];
			r.pins_enable[p] = (nib[gpioei_pkg::ModeMsb : gpioei_pkg::ModeLsb] != 2'b00) &&
				(!nib[gpioei_pkg::OpenDrainBit] || !out_levels[p]);
		end
		r.pins_drive = out_levels;
		r.irq = |(pending & irq_en);
		port_results_due.push_back(r);
	endtask

	task automatic queue_word(input gpioei_pkg::cmd_t c, input logic [3:0] idx,
			input logic [gpioei_pkg::DataW-1:0] d, input logic [gpioei_pkg::PortW-1:0] p,
			input idle_phase_t ph);
		queued_word_t q;
		q.word.command = c;
		q.word.reg_index = idx;
		q.word.write_data = d;
		q.word.pins_in = p;
		q.phase = ph;
		words_to_send.push_back(q);
	endtask

	task automatic check_field(input string name, input logic [gpioei_pkg::DataW-1:0] want,
			input logic [gpioei_pkg::DataW-1:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= ReportedFaults)
				$display("Mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Driver: presents queued words and predicts each one as it is accepted.
	always @(posedge clk) begin : word_driver
		queued_word_t nxt;
		bit idle;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_bus_word(gpioei_pkg::item_t'{command, reg_index, write_data, pins_in});
				words_accepted <= words_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				idle = 1'b1;
				if (words_to_send.size() != 0) begin
					case (words_to_send[0].phase)
						PH_SLOW_SINK:   idle = $urandom_range(0, 99) < 37;
						PH_SLOW_SOURCE: idle = $urandom_range(0, 99) < 62;
						default:        idle = 1'b0;
					endcase
				end
				if (!idle) begin
					nxt = words_to_send.pop_front();
					command <= nxt.word.command;
					reg_index <= nxt.word.reg_index;
					write_data <= nxt.word.write_data;
					pins_in <= nxt.word.pins_in;
					idle_phase <= nxt.phase;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result stall: random per phase, plus one long hold-off to fill the port up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && words_accepted >= HoldAfterWords) begin
				out_stall <= 1'b1;
				hold_left <= HoldCycles;
				hold_done <= 1'b1;
			end else begin
				case (idle_phase)
					PH_SLOW_SINK:   out_stall <= $urandom_range(0, 99) < 62;
					PH_SLOW_SOURCE: out_stall <= $urandom_range(0, 99) < 37;
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Monitor: every accepted result is checked against the oldest one due.
	always @(posedge clk) begin : result_monitor
		gpioei_pkg::result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (port_results_due.size() == 0) begin
				fault_count++;
				if (fault_count <= ReportedFaults)
					$display("Result word with none due: read_data %h", read_data);
			end else begin
				due = port_results_due.pop_front();
				check_field("read_data", due.read_data, read_data);
				check_field("pins_drive", {24'b0, due.pins_drive}, {24'b0, pins_drive});
				check_field("pins_enable", {24'b0, due.pins_enable}, {24'b0, pins_enable});
				check_field("irq", {31'b0, due.irq}, {31'b0, irq});
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int unsigned i;
		int unsigned r;
		idle_phase_t ph;
		logic [3:0] idx;

		// Directed words: reset values, unmapped and write-only registers, extremes, edges.
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_CONFIG, '0, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_PENDING, '1, '1, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_CONFIG, 32'hffff_ffff, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_OUTPUT, 32'hffff_ffff, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_CLEAR, 32'hffff_ff0f, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_SET, 32'h0000_0003, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_SET, '0, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_CLEAR, '0, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_INPUT, 32'hffff_ffff, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, RegUnmappedLo, 32'hffff_ffff, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, RegUnmappedHi, 32'hffff_ffff, '1, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_NONE, gpioei_pkg::REG_CONFIG, 32'hffff_ffff, '1,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_CONFIG, 32'h1111_1111, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_IRQ_EN, 32'hffff_ffff, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_RISE_EN, 32'h0000_000f, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_FALL_EN, 32'h0000_00f0, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_SAMPLE, gpioei_pkg::REG_CONFIG, '0, 8'hff, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_SAMPLE, gpioei_pkg::REG_CONFIG, '0, 8'h00, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_INPUT, '0, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_PENDING, '0, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_PENDING, 32'hffff_ffff, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_IRQ_EN, 32'h0000_0000, '0,
			PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_SAMPLE, gpioei_pkg::REG_CONFIG, '0, 8'haa, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_READ, gpioei_pkg::REG_PENDING, '0, '0, PH_SLOW_SINK);
		queue_word(gpioei_pkg::CMD_WRITE, gpioei_pkg::REG_CONFIG, 32'h0000_0000, '0,
			PH_SLOW_SINK);

		// Random words: mostly samples and register writes, with reads and no-op words mixed in.
		for (i = 0; i < RandomWords; i++) begin
			if (i < RandomWords / 3)
				ph = PH_SLOW_SINK;
			else if (i < 2 * RandomWords / 3)
				ph = PH_SLOW_SOURCE;
			else
				ph = PH_FULL_RATE;
			idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			r = $urandom_range(0, 99);
			if (r < 35)
				queue_word(gpioei_pkg::CMD_SAMPLE, 4'($urandom), $urandom, 8'($urandom), ph);
			else if (r < 65)
				queue_word(gpioei_pkg::CMD_WRITE, idx, $urandom, 8'($urandom), ph);
			else if (r < 93)
				queue_word(gpioei_pkg::CMD_READ, idx, $urandom, 8'($urandom), ph);
			else
				queue_word(gpioei_pkg::CMD_NONE, idx, $urandom, 8'($urandom), ph);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to be taken and every result to arrive.
		while (words_to_send.size() != 0 || in_valid || port_results_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fault_count == 0 && port_results_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/gpioei_pkg.sv
rtl/gpioei_core.sv
rtl/gpio_port_with_edge_interrupts.sv
rtl/gpioei_checker.sv
verif/tb_top.sv
